// File: hw/rtl/arup_pkg.sv
package arup_pkg;

   localparam int CHAN_W = 8;
   localparam int DIV_W  = 2 * CHAN_W;
   localparam int LANES  = 3;
   localparam int STEPS  = CHAN_W;

   localparam logic [CHAN_W-1:0] CHAN_MAX  = {CHAN_W{1'b1}};
   localparam logic [CHAN_W-1:0] CHAN_ZERO = {CHAN_W{1'b0}};

   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic [CHAN_W-1:0] alpha_in;
   } pixel_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] alpha_out;
   } pixel_out_type;

   // One color lane of a division in flight. The work word starts as the
   // low dividend byte; each step shifts one dividend bit out at the top and
   // one quotient bit in at the bottom.
   typedef struct packed {
      logic              sat;
      logic [CHAN_W-1:0] rem;
      logic [CHAN_W-1:0] work;
   } lane_type;

   typedef struct packed {
      logic [CHAN_W-1:0]            alpha;
      lane_type [LANES-1:0]         lane;
   } stage_type;

endpackage

// File: hw/rtl/arup_front.sv
module arup_front
   import arup_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  pixel_in_type up_data,
   output logic         dn_valid,
   input  logic         dn_ready,
   output stage_type    dn_data
);

   logic              valid_ff;
   logic              valid_in;
   stage_type         data_ff;
   stage_type         data_in;
   logic [CHAN_W-1:0] chan [LANES];
   logic [DIV_W-1:0]  dividend [LANES];

   assign chan[LANE_RED]   = up_data.red_in;
   assign chan[LANE_GREEN] = up_data.green_in;
   assign chan[LANE_BLUE]  = up_data.blue_in;

   // Dividend is c*255 + alpha/2, formed as (c << 8) - c + (alpha >> 1).
   // If its high byte already reaches alpha, the quotient is above 255.
   always_comb begin
      data_in.alpha = up_data.alpha_in;
      for (int i = 0; i < LANES; i++) begin
         dividend[i] = {chan[i], CHAN_ZERO} - DIV_W'(chan[i])
                       + DIV_W'(up_data.alpha_in >> 1);
         data_in.lane[i].rem  = dividend[i][DIV_W-1:CHAN_W];
         data_in.lane[i].work = dividend[i][CHAN_W-1:0];
         data_in.lane[i].sat  = (dividend[i][DIV_W-1:CHAN_W] >= up_data.alpha_in);
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: hw/rtl/arup_cell.sv
module arup_cell
   import arup_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      up_valid,
   output logic      up_ready,
   input  stage_type up_data,
   output logic      dn_valid,
   input  logic      dn_ready,
   output stage_type dn_data
);

   logic              valid_ff;
   logic              valid_in;
   stage_type         data_ff;
   stage_type         data_in;
   logic [CHAN_W:0]   trial [LANES];
   logic              fits  [LANES];

   // One restoring step per lane: bring down the next dividend bit and
   // subtract alpha if the partial remainder allows it.
   always_comb begin
      data_in = up_data;
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {up_data.lane[i].rem, up_data.lane[i].work[CHAN_W-1]};
         fits[i]  = (trial[i] >= {1'b0, up_data.alpha});
         data_in.lane[i].rem  = fits[i] ? CHAN_W'(trial[i] - {1'b0, up_data.alpha})
                                        : trial[i][CHAN_W-1:0];
         data_in.lane[i].work = {up_data.lane[i].work[CHAN_W-2:0], fits[i]};
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: hw/rtl/rgba_alpha_unpremultiply.sv
// RGBA alpha unpremultiply, 8 bits per channel.
//
// A premultiplied pixel is offered on the req_ channel (req_valid, req_ready,
// req_data) and the straight-alpha pixel leaves on the rsp_ channel (rsp_valid,
// rsp_ready, rsp_data). Each color becomes (c*255 + alpha/2) / alpha, rounded
// and saturated at 255; alpha 0 gives black color channels, and alpha passes
// through unchanged.
//
// From an accepted request to its response the pixel passes one entry
// stage that forms the dividends, then a row of 8 identical cells that each
// retires one quotient bit for all three color lanes. Throughput is one
// pixel per clock while rsp_ready stays high, set by the one-bit-per-cell
// division chain which takes a new pixel every cycle unless stalled.
//
// Every stage has its own valid bit and accepts new data when it is empty or
// its neighbor takes its contents, so bubbles close up. When the receiver
// stalls, the response holds steady and up to 9 requests queue in the chain
// before req_ready drops. Reset clears the valid bits only; the block keeps
// no other state.
module rgba_alpha_unpremultiply
   import arup_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  pixel_in_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output pixel_out_type rsp_data
);

   stage_type      link       [STEPS+1];
   logic [STEPS:0] link_valid;
   logic [STEPS:0] link_ready;
   logic [CHAN_W-1:0] result  [LANES];

   arup_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_data),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0]),
      .dn_data  (link[0])
   );

   for (genvar s = 0; s < STEPS; s++) begin : g_cell
      arup_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[s]),
         .up_ready (link_ready[s]),
         .up_data  (link[s]),
         .dn_valid (link_valid[s+1]),
         .dn_ready (link_ready[s+1]),
         .dn_data  (link[s+1])
      );
   end

   assign link_ready[STEPS] = rsp_ready;
   assign rsp_valid         = link_valid[STEPS];

   // After the last cell the work word holds the quotient. A transparent
   // pixel forces black, and an overflowing lane clamps to full scale.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (link[STEPS].alpha == CHAN_ZERO) begin
            result[i] = CHAN_ZERO;
         end else if (link[STEPS].lane[i].sat) begin
            result[i] = CHAN_MAX;
         end else begin
            result[i] = link[STEPS].lane[i].work;
         end
      end
   end

   assign rsp_data.red_out   = result[LANE_RED];
   assign rsp_data.green_out = result[LANE_GREEN];
   assign rsp_data.blue_out  = result[LANE_BLUE];
   assign rsp_data.alpha_out = link[STEPS].alpha;

   // A request entering an empty chain reaches the output with its alpha.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (link_valid == '0)) |-> ##9
      (rsp_valid && rsp_data.alpha_out == $past(req_data.alpha_in, 9)))
      else $error("request did not reach the output after the chain latency");

   // With every stage full and the receiver stalled, no request may enter.
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      ((&link_valid) && !rsp_ready) |-> !req_ready)
      else $error("request accepted into a full stalled chain");

   // A transparent pixel always leaves with black color channels.
   a_transparent : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.alpha_out == CHAN_ZERO) |->
      (rsp_data.red_out == CHAN_ZERO && rsp_data.green_out == CHAN_ZERO
       && rsp_data.blue_out == CHAN_ZERO))
      else $error("transparent pixel left with color");

endmodule
